// ===== sv/akaf_pkg.sv =====
// ----------------------------------------------------------------------------
// akaf_pkg
// Shared types and constants of the angle fusion Kalman core.
// ----------------------------------------------------------------------------
package akaf_pkg;

  localparam int unsigned RegW = 31;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 5;

  localparam logic [RegW-1:0] GyroNoiseRst  = 31'd805306;
  localparam logic [RegW-1:0] MeasNoiseRst  = 31'd134217728;
  localparam logic [RegW-1:0] TimeStepRst   = 31'd2684355;
  localparam logic [RegW-1:0] NoiseHighRst  = 31'd10737418;
  localparam logic [RegW-1:0] NoiseMidRst   = 31'd2684355;
  localparam logic [RegW-1:0] NoiseLowRst   = 31'd1073742;
  localparam logic [RegW-1:0] LimitHighRst  = 31'd4915200;
  localparam logic [RegW-1:0] LimitMidRst   = 31'd1310720;
  localparam logic signed [31:0] Q28One     = 32'sd268435456;

  localparam logic [2:0] RegGyroNoise = 3'd0;
  localparam logic [2:0] RegMeasNoise = 3'd1;
  localparam logic [2:0] RegTimeStep  = 3'd2;
  localparam logic [2:0] RegNoiseHigh = 3'd3;
  localparam logic [2:0] RegNoiseMid  = 3'd4;
  localparam logic [2:0] RegNoiseLow  = 3'd5;
  localparam logic [2:0] RegLimitHigh = 3'd6;
  localparam logic [2:0] RegLimitMid  = 3'd7;

  typedef struct packed {
    logic [RegW-1:0] gyro_noise;
    logic [RegW-1:0] meas_noise;
    logic [RegW-1:0] time_step;
    logic [RegW-1:0] noise_high;
    logic [RegW-1:0] noise_mid;
    logic [RegW-1:0] noise_low;
    logic [RegW-1:0] limit_high;
    logic [RegW-1:0] limit_mid;
  } cfg_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) + 34'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return sat34(34'(a) - 34'(b));
  endfunction

endpackage

// ===== sv/akaf_regs.sv =====
// ----------------------------------------------------------------------------
// akaf_regs
// APB register file holding the eight filter tuning registers.
// ----------------------------------------------------------------------------
module akaf_regs import akaf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic [RegW-1:0] rd_val;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gyro_noise <= GyroNoiseRst;
      cfg_q.meas_noise <= MeasNoiseRst;
      cfg_q.time_step  <= TimeStepRst;
      cfg_q.noise_high <= NoiseHighRst;
      cfg_q.noise_mid  <= NoiseMidRst;
      cfg_q.noise_low  <= NoiseLowRst;
      cfg_q.limit_high <= LimitHighRst;
      cfg_q.limit_mid  <= LimitMidRst;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        RegGyroNoise: cfg_q.gyro_noise <= pwdata[RegW-1:0];
        RegMeasNoise: cfg_q.meas_noise <= pwdata[RegW-1:0];
        RegTimeStep:  cfg_q.time_step  <= pwdata[RegW-1:0];
        RegNoiseHigh: cfg_q.noise_high <= pwdata[RegW-1:0];
        RegNoiseMid:  cfg_q.noise_mid  <= pwdata[RegW-1:0];
        RegNoiseLow:  cfg_q.noise_low  <= pwdata[RegW-1:0];
        RegLimitHigh: cfg_q.limit_high <= pwdata[RegW-1:0];
        RegLimitMid:  cfg_q.limit_mid  <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      RegGyroNoise: rd_val = cfg_q.gyro_noise;
      RegMeasNoise: rd_val = cfg_q.meas_noise;
      RegTimeStep:  rd_val = cfg_q.time_step;
      RegNoiseHigh: rd_val = cfg_q.noise_high;
      RegNoiseMid:  rd_val = cfg_q.noise_mid;
      RegNoiseLow:  rd_val = cfg_q.noise_low;
      RegLimitHigh: rd_val = cfg_q.limit_high;
      RegLimitMid:  rd_val = cfg_q.limit_mid;
      default:      rd_val = '0;
    endcase
  end

  assign prdata = (paddr[1:0] == 2'b00) ? {1'b0, rd_val} : '0;

endmodule

// ===== sv/akaf_mul.sv =====
// ----------------------------------------------------------------------------
// akaf_mul
// Registered 32x32 signed multiply with Q28 rounding and saturation.
// Both the raw product and the rounded, saturated result are registered.
// ----------------------------------------------------------------------------
module akaf_mul import akaf_pkg::*; (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] p_o
);

  logic signed [63:0] prod_q;
  logic signed [63:0] prod_d;
  logic signed [31:0] p_q;
  logic signed [31:0] p_d;
  logic signed [36:0] shifted;

  assign prod_d = 64'(a_i) * 64'(b_i);

  // Add half an LSB then floor-shift by 28; the top of the result decides
  // saturation.
  always_comb begin
    shifted = 37'((65'(prod_q) + 65'sd134217728) >>> 28);
    if (shifted > 37'sh0_7FFF_FFFF) p_d = 32'sh7FFF_FFFF;
    else if (shifted < -37'sh0_8000_0000) p_d = 32'sh8000_0000;
    else p_d = shifted[31:0];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    p_q    <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== sv/akaf_div.sv =====
// ----------------------------------------------------------------------------
// akaf_div
// Restoring divider, one quotient bit per cycle: (num * 2^28) / den with
// den > 0, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module akaf_div import akaf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);

  // |num| * 2^28 fits in 60 bits.
  localparam int unsigned NW = 60;

  logic [NW-1:0] dvd_q, dvd_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [31:0]   rem_q, rem_d;
  logic [30:0]   den_q;
  logic          neg_q;
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [32:0]   trial;
  logic [NW:0]   sq;
  logic [31:0]   mag;

  always_comb begin
    trial = {rem_q, dvd_q[NW-1]} - {2'b0, den_q};
    dvd_d = dvd_q << 1;
    if (!trial[32]) begin
      rem_d = trial[31:0];
      quo_d = {quo_q[NW-2:0], 1'b1};
    end else begin
      rem_d = {rem_q[30:0], dvd_q[NW-1]};
      quo_d = {quo_q[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(NW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
        cnt_q <= cnt_q - 6'd1;
      end
    end
  end

  assign mag = num_i[31] ? 32'(-33'(num_i)) : num_i;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag[31:0], 28'd0};
      quo_q <= '0;
      rem_q <= '0;
      den_q <= den_i[30:0];
      neg_q <= num_i[31];
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    sq = neg_q ? -({1'b0, quo_q}) : {1'b0, quo_q};
    if (!neg_q && quo_q > 60'h0_7FFF_FFFF) quo_o = 32'sh7FFF_FFFF;
    else if (neg_q && quo_q > 60'h0_8000_0000) quo_o = 32'sh8000_0000;
    else quo_o = sq[31:0];
  end

endmodule

// ===== sv/adaptive_kalman_angle_fusion_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_kalman_angle_fusion_core
// Two-state Kalman filter (angle and gyro bias) fusing an accelerometer angle
// with a gyro rate, built round one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  accel_angle_i, gyro_rate_i
// out       output     out_valid_o/out_stall_i angle/rate/bias_estimate_o
// cfg       input      APB psel/penable       paddr, pwdata, prdata
//
// The first word after reset presents its result the cycle after acceptance.
// Every later word runs ten products through the two-stage multiplier and,
// when the innovation variance is positive, two 60-step divisions, which
// take most of its time; otherwise the gains are forced to zero and no
// division runs. in_stall_o is high from the acceptance of a word until its
// result has left the output register, so one word is in flight at a time.
// Reset restores the register defaults and the filter state (unit
// covariance, not started). A stalled output word simply holds; nothing
// else is lost.
// ----------------------------------------------------------------------------
module adaptive_kalman_angle_fusion_core import akaf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] accel_angle_i,
  input  logic signed [31:0] gyro_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] angle_estimate_o,
  output logic signed [31:0] rate_estimate_o,
  output logic signed [31:0] bias_estimate_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MWAIT, S_DIV0, S_DWAIT0, S_DIV1, S_DWAIT1, S_UPD, S_OUT
  } state_e;

  cfg_t cfg;
  state_e state_q;
  logic started_q;
  logic signed [31:0] angle_q, bias_q, c00_q, c01_q, c10_q, c11_q;
  logic signed [31:0] acc_q, gyr_q;
  logic signed [31:0] p00_q, p01_q, p10_q, p11_q, err_q, e_q, k0_q, k1_q, d00_q;
  logic [3:0] step_q;
  logic [1:0] wait_q;
  logic signed [31:0] ma, mb, mp;
  logic div_start;
  logic signed [31:0] div_num;
  logic div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] dt, corr, qa;
  logic [32:0] mag;

  akaf_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  akaf_mul u_mul (.clk_i, .a_i(ma), .b_i(mb), .p_o(mp));

  akaf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(e_q),
    .done_o(div_done), .quo_o(div_q)
  );

  assign dt   = {1'b0, cfg.time_step};
  assign corr = sub_sat(gyr_q, bias_q);
  assign mag  = gyr_q[31] ? 33'(-34'(gyr_q)) : {1'b0, gyr_q};

  always_comb begin
    if (mag > {2'b0, cfg.limit_high}) qa = {1'b0, cfg.noise_high};
    else if (mag > {2'b0, cfg.limit_mid}) qa = {1'b0, cfg.noise_mid};
    else qa = {1'b0, cfg.noise_low};
  end

  // Multiplier operand schedule. Steps 0..3 form the prediction, 4..9 the
  // correction once the gains are known.
  always_comb begin
    ma = dt;
    mb = corr;
    case (step_q)
      4'd0: begin ma = corr;  mb = dt; end
      4'd1: begin ma = d00_q; mb = dt; end
      4'd2: begin ma = c11_q; mb = dt; end
      4'd3: begin ma = {1'b0, cfg.gyro_noise}; mb = dt; end
      4'd4: begin ma = k0_q;  mb = p00_q; end
      4'd5: begin ma = k0_q;  mb = p01_q; end
      4'd6: begin ma = k1_q;  mb = p00_q; end
      4'd7: begin ma = k1_q;  mb = p01_q; end
      4'd8: begin ma = k0_q;  mb = err_q; end
      4'd9: begin ma = k1_q;  mb = err_q; end
      default: ;
    endcase
  end

  assign div_start = (state_q == S_DIV0) || (state_q == S_DIV1);
  assign div_num   = (state_q == S_DIV0) ? p00_q : p10_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      started_q <= 1'b0;
      angle_q   <= '0;
      bias_q    <= '0;
      c00_q     <= Q28One;
      c01_q     <= '0;
      c10_q     <= '0;
      c11_q     <= Q28One;
      step_q    <= '0;
      wait_q    <= '0;
      rate_estimate_o <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            acc_q <= accel_angle_i;
            gyr_q <= gyro_rate_i;
            if (!started_q) begin
              started_q <= 1'b1;
              angle_q   <= accel_angle_i;
              bias_q    <= '0;
              rate_estimate_o <= '0;
              state_q   <= S_OUT;
            end else begin
              step_q  <= 4'd0;
              wait_q  <= 2'd2;
              state_q <= S_MWAIT;
            end
          end
        end
        S_MUL: begin
          wait_q  <= 2'd2;
          state_q <= S_MWAIT;
        end
        S_MWAIT: begin
          if (wait_q != 2'd0) begin
            wait_q <= wait_q - 2'd1;
            if (wait_q == 2'd2 && step_q == 4'd0)
              d00_q <= sub_sat(sub_sat(qa, c01_q), c10_q);
          end else begin
            step_q  <= step_q + 4'd1;
            state_q <= S_MUL;
            case (step_q)
              4'd0: begin
                angle_q <= add_sat(angle_q, mp);
                err_q   <= sub_sat(acc_q, add_sat(angle_q, mp));
              end
              4'd1: begin
                p00_q <= add_sat(c00_q, mp);
                e_q   <= add_sat({1'b0, cfg.meas_noise}, add_sat(c00_q, mp));
              end
              4'd2: begin
                p01_q <= sub_sat(c01_q, mp);
                p10_q <= sub_sat(c10_q, mp);
              end
              4'd3: begin
                p11_q <= add_sat(c11_q, mp);
                if (e_q > 0) state_q <= S_DIV0;
                else begin
                  k0_q <= '0;
                  k1_q <= '0;
                end
              end
              4'd4: c00_q <= sub_sat(p00_q, mp);
              4'd5: c01_q <= sub_sat(p01_q, mp);
              4'd6: c10_q <= sub_sat(p10_q, mp);
              4'd7: c11_q <= sub_sat(p11_q, mp);
              4'd8: angle_q <= add_sat(angle_q, mp);
              4'd9: begin
                bias_q  <= add_sat(bias_q, mp);
                state_q <= S_UPD;
              end
              default: ;
            endcase
          end
        end
        S_DIV0: state_q <= S_DWAIT0;
        S_DWAIT0: begin
          if (div_done) begin
            k0_q    <= div_q;
            state_q <= S_DIV1;
          end
        end
        S_DIV1: state_q <= S_DWAIT1;
        S_DWAIT1: begin
          if (div_done) begin
            k1_q    <= div_q;
            state_q <= S_MUL;
          end
        end
        S_UPD: begin
          rate_estimate_o <= sub_sat(gyr_q, bias_q);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign angle_estimate_o = angle_q;
  assign bias_estimate_o  = bias_q;

endmodule
